[rtl/core/radial_spotlight_brighten_top_macros.svh]
// Assertion macros for the radial spotlight core.
// RSB_ASSERT_NOW  : antecedent and consequent in the same cycle, muted in reset.
// RSB_ASSERT_NEXT : consequent in the cycle after the antecedent, live in reset.
`ifndef RADIAL_SPOTLIGHT_BRIGHTEN_TOP_MACROS_SVH
`define RADIAL_SPOTLIGHT_BRIGHTEN_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define RSB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spotlight core: same-cycle check failed");

`define RSB_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("spotlight core: next-cycle check failed");

`else

`define RSB_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define RSB_ASSERT_NEXT(label, clk, ante, cons)

`endif

`endif

[rtl/core/rsb_pkg.sv]
`default_nettype none

package rsb_pkg;

    // Coordinate width of the pixel stream
    localparam int COORD_BITS = 12;

    // Register widths
    localparam int DIM_W  = 13;
    localparam int RAD_W  = 21;
    localparam int INV_W  = 25;
    localparam int CFG_W  = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CHAN_W = 8;

    // Fixed-point layout
    localparam int FRAC_W   = 14;
    localparam int RQ_SHIFT = 18;
    localparam int GAIN_W   = 16;
    localparam logic [FRAC_W:0] ONE_Q14 = (FRAC_W + 1)'(16384);
    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(57344);

    // Derived datapath widths
    localparam int DIFF_W      = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int SUM_W       = SQ_W + 1;
    localparam int RAD_IN_W    = SUM_W + FRAC_W;
    localparam int ROOT_W      = (RAD_IN_W + 1) / 2;
    localparam int RADICAND_W  = 2 * ROOT_W;
    localparam int CMP_W       = (ROOT_W > RAD_W) ? ROOT_W : RAD_W;
    localparam int PROD_W      = ROOT_W + INV_W;
    localparam int CPROD_W     = CHAN_W + GAIN_W;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_ENABLE   = 3'd0,
        REG_FRAME_WIDTH    = 3'd1,
        REG_FRAME_HEIGHT   = 3'd2,
        REG_RADIUS_FIXED   = 3'd3,
        REG_INVERSE_RADIUS = 3'd4
    } t_reg_idx;

    // Reset values
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH    = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT   = DIM_W'(480);
    localparam logic [RAD_W-1:0] RST_RADIUS_FIXED   = RAD_W'(55296);
    localparam logic [INV_W-1:0] RST_INVERSE_RADIUS = INV_W'(77672);

    typedef struct packed {
        logic               light_enable;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [RAD_W-1:0]   radius_fixed;
        logic [INV_W-1:0]   inverse_radius;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [CHAN_W-1:0]     in_red;
        logic [CHAN_W-1:0]     in_green;
        logic [CHAN_W-1:0]     in_blue;
        logic [CHAN_W-1:0]     in_alpha;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } t_out_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_rgba;

    // Gain stage to scaling stage
    typedef struct packed {
        logic              in_disc;
        logic [GAIN_W-1:0] gain;
        t_rgba             pix;
    } t_gain_beat;

endpackage

`default_nettype wire

[rtl/core/radial_spotlight_brighten_top.sv]
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_beat (rsb_pkg::t_in_beat)
// output    out        o_valid / i_stall   o_beat (rsb_pkg::t_out_beat)
// config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// One pixel enters per clock while o_stall is low; the square root resolves
// one root bit per stage. Reset (synchronous, active low) empties every stage
// and loads the register defaults. Stages advance independently: an empty
// stage fills even while the output beat is held, so o_stall rises only when
// every stage holds a beat.
`default_nettype none
`include "radial_spotlight_brighten_top_macros.svh"

module radial_spotlight_brighten_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rsb_pkg::t_in_beat    i_beat,
    // pixel output
    output logic                 o_valid,
    input  logic                 i_stall,
    output rsb_pkg::t_out_beat   o_beat,
    // register writes
    input  logic                 i_cfg_we,
    input  logic [rsb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rsb_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int DIM_W = rsb_pkg::DIM_W;
    localparam int RAD_W = rsb_pkg::RAD_W;
    localparam int INV_W = rsb_pkg::INV_W;

    rsb_pkg::t_cfg r_cfg;

    logic                             w_off_ready, w_off_valid;
    logic [rsb_pkg::RADICAND_W-1:0]   w_radicand;
    rsb_pkg::t_rgba                   w_off_pix;

    logic                             w_sqrt_ready, w_sqrt_valid;
    logic [rsb_pkg::ROOT_W-1:0]       w_root;
    rsb_pkg::t_rgba                   w_sqrt_pix;

    logic                             w_gain_ready, w_gain_valid;
    rsb_pkg::t_gain_beat              w_gain_beat;

    logic                             w_scale_ready;

    // Register file: keep only each register's width, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_enable   <= 1'b0;
            r_cfg.frame_width    <= rsb_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height   <= rsb_pkg::RST_FRAME_HEIGHT;
            r_cfg.radius_fixed   <= rsb_pkg::RST_RADIUS_FIXED;
            r_cfg.inverse_radius <= rsb_pkg::RST_INVERSE_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rsb_pkg::REG_LIGHT_ENABLE:   r_cfg.light_enable   <= i_cfg_data[0];
                rsb_pkg::REG_FRAME_WIDTH:    r_cfg.frame_width    <= i_cfg_data[DIM_W-1:0];
                rsb_pkg::REG_FRAME_HEIGHT:   r_cfg.frame_height   <= i_cfg_data[DIM_W-1:0];
                rsb_pkg::REG_RADIUS_FIXED:   r_cfg.radius_fixed   <= i_cfg_data[RAD_W-1:0];
                rsb_pkg::REG_INVERSE_RADIUS: r_cfg.inverse_radius <= i_cfg_data[INV_W-1:0];
                default:                     r_cfg                <= r_cfg;
            endcase
        end
    end

    // Offsets, squares and radicand: three stages
    rsb_offset_sq u_offset_sq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (w_off_ready),
        .i_beat     (i_beat),
        .o_valid    (w_off_valid),
        .i_ready    (w_sqrt_ready),
        .o_radicand (w_radicand),
        .o_pix      (w_off_pix)
    );

    // Distance in Q13.8: one root bit per stage
    rsb_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_off_valid),
        .o_ready    (w_sqrt_ready),
        .i_radicand (w_radicand),
        .i_pix      (w_off_pix),
        .o_valid    (w_sqrt_valid),
        .i_ready    (w_gain_ready),
        .o_root     (w_root),
        .o_pix      (w_sqrt_pix)
    );

    // Inside test, ratio and gain: two stages
    rsb_gain u_gain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (w_sqrt_valid),
        .o_ready    (w_gain_ready),
        .i_root     (w_root),
        .i_pix      (w_sqrt_pix),
        .o_valid    (w_gain_valid),
        .i_ready    (w_scale_ready),
        .o_beat     (w_gain_beat)
    );

    // Channel products, saturation and output register: two stages
    rsb_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_light_enable (r_cfg.light_enable),
        .i_valid        (w_gain_valid),
        .o_ready        (w_scale_ready),
        .i_beat         (w_gain_beat),
        .o_valid        (o_valid),
        .i_ready        (!i_stall),
        .o_beat         (o_beat)
    );

    assign o_stall = !w_off_ready;

    // Back-pressure reaches the input only with a held beat at the output
    `RSB_ASSERT_NOW(a_stall_needs_held_out, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    // Reset leaves the pipeline empty and open
    `RSB_ASSERT_NEXT(a_reset_empties, i_clk, !i_rst_n, !o_valid && !o_stall)
    // Gain stays between one and 3.5 in Q2.14
    `RSB_ASSERT_NOW(a_gain_range, i_clk, i_rst_n, w_gain_valid,
        (w_gain_beat.gain >= 16'(rsb_pkg::ONE_Q14)) && (w_gain_beat.gain <= rsb_pkg::GAIN_MAX))

endmodule

`default_nettype wire

[rtl/core/rsb_offset_sq.sv]
`default_nettype none

module rsb_offset_sq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsb_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  rsb_pkg::t_in_beat i_beat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [rsb_pkg::RADICAND_W-1:0] o_radicand,
    output rsb_pkg::t_rgba    o_pix
);

    localparam int DIFF_W     = rsb_pkg::DIFF_W;
    localparam int SQ_W       = rsb_pkg::SQ_W;
    localparam int SUM_W      = rsb_pkg::SUM_W;
    localparam int RADICAND_W = rsb_pkg::RADICAND_W;
    localparam int FRAC_W     = rsb_pkg::FRAC_W;
    localparam int N          = 3;

    logic             r_valid [N];
    logic [N:0]       w_ld;

    logic [DIFF_W-1:0] r_dx, r_dy, n_dx, n_dy;
    logic [SQ_W-1:0]   r_sqx, r_sqy, n_sqx, n_sqy;
    logic [RADICAND_W-1:0] r_rad, n_rad;
    rsb_pkg::t_rgba    r_pix0, r_pix1, r_pix2, n_pix0;

    logic [DIFF_W-1:0] w_x2, w_y2, w_w, w_h;
    logic [SUM_W-1:0]  w_sum;

    // Advance a stage when it is empty or its successor advances
    assign w_ld[N] = i_ready;
    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_ld
            assign w_ld[k] = !r_valid[k] || w_ld[k+1];
        end
    endgenerate
    assign o_ready = w_ld[0];

    // Doubled offsets from the frame centre
    assign w_x2 = DIFF_W'({i_beat.pixel_x, 1'b0});
    assign w_y2 = DIFF_W'({i_beat.pixel_y, 1'b0});
    assign w_w  = DIFF_W'(i_cfg.frame_width);
    assign w_h  = DIFF_W'(i_cfg.frame_height);
    assign n_dx = (w_x2 >= w_w) ? (w_x2 - w_w) : (w_w - w_x2);
    assign n_dy = (w_y2 >= w_h) ? (w_y2 - w_h) : (w_h - w_y2);
    assign n_pix0 = '{red:   i_beat.in_red,
                      green: i_beat.in_green,
                      blue:  i_beat.in_blue,
                      alpha: i_beat.in_alpha};

    assign n_sqx = SQ_W'(r_dx) * SQ_W'(r_dx);
    assign n_sqy = SQ_W'(r_dy) * SQ_W'(r_dy);

    assign w_sum = SUM_W'(r_sqx) + SUM_W'(r_sqy);
    assign n_rad = RADICAND_W'({w_sum, {FRAC_W{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
            r_valid[1] <= 1'b0;
            r_valid[2] <= 1'b0;
        end else begin
            if (w_ld[0]) r_valid[0] <= i_valid;
            if (w_ld[1]) r_valid[1] <= r_valid[0];
            if (w_ld[2]) r_valid[2] <= r_valid[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_pix0 <= n_pix0;
        end
        if (w_ld[1]) begin
            r_sqx  <= n_sqx;
            r_sqy  <= n_sqy;
            r_pix1 <= r_pix0;
        end
        if (w_ld[2]) begin
            r_rad  <= n_rad;
            r_pix2 <= r_pix1;
        end
    end

    assign o_valid    = r_valid[N-1];
    assign o_radicand = r_rad;
    assign o_pix      = r_pix2;

endmodule

`default_nettype wire

[rtl/core/rsb_isqrt.sv]
`default_nettype none

module rsb_isqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [rsb_pkg::RADICAND_W-1:0] i_radicand,
    input  rsb_pkg::t_rgba i_pix,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [rsb_pkg::ROOT_W-1:0] o_root,
    output rsb_pkg::t_rgba o_pix
);

    localparam int ROOT_W     = rsb_pkg::ROOT_W;
    localparam int RADICAND_W = rsb_pkg::RADICAND_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int N          = ROOT_W;

    logic                  r_valid [N];
    logic [RADICAND_W-1:0] r_rad   [N];
    logic [REM_W-1:0]      r_rem   [N];
    logic [ROOT_W-1:0]     r_root  [N];
    rsb_pkg::t_rgba        r_pix   [N];
    logic [N:0]            w_ld;

    assign w_ld[N] = i_ready;
    assign o_ready = w_ld[0];

    // One root bit per stage, two radicand bits consumed per stage
    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_step
            logic                  w_pv;
            logic [RADICAND_W-1:0] w_prad;
            logic [REM_W-1:0]      w_prem;
            logic [ROOT_W-1:0]     w_proot;
            rsb_pkg::t_rgba        w_ppix;
            logic [REM_W-1:0]      w_shift, w_trial, n_rem;
            logic [ROOT_W-1:0]     n_root;

            if (k == 0) begin : g_first
                assign w_pv    = i_valid;
                assign w_prad  = i_radicand;
                assign w_prem  = '0;
                assign w_proot = '0;
                assign w_ppix  = i_pix;
            end else begin : g_next
                assign w_pv    = r_valid[k-1];
                assign w_prad  = r_rad[k-1];
                assign w_prem  = r_rem[k-1];
                assign w_proot = r_root[k-1];
                assign w_ppix  = r_pix[k-1];
            end

            assign w_ld[k]  = !r_valid[k] || w_ld[k+1];
            assign w_shift  = {w_prem[REM_W-3:0], w_prad[RADICAND_W-1-2*k -: 2]};
            assign w_trial  = {1'b0, w_proot, 2'b01};

            always_comb begin
                if (w_shift >= w_trial) begin
                    n_rem  = w_shift - w_trial;
                    n_root = {w_proot[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = w_shift;
                    n_root = {w_proot[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (w_ld[k]) begin
                    r_valid[k] <= w_pv;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_ld[k]) begin
                    r_rad[k]  <= w_prad;
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                    r_pix[k]  <= w_ppix;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[N-1];
    assign o_root  = r_root[N-1];
    assign o_pix   = r_pix[N-1];

endmodule

`default_nettype wire

[rtl/core/rsb_gain.sv]
`default_nettype none

module rsb_gain (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rsb_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [rsb_pkg::ROOT_W-1:0] i_root,
    input  rsb_pkg::t_rgba i_pix,
    output logic           o_valid,
    input  logic           i_ready,
    output rsb_pkg::t_gain_beat o_beat
);

    localparam int CMP_W    = rsb_pkg::CMP_W;
    localparam int PROD_W   = rsb_pkg::PROD_W;
    localparam int RQ_SHIFT = rsb_pkg::RQ_SHIFT;
    localparam int RQ_W     = PROD_W - RQ_SHIFT;
    localparam int FRAC_W   = rsb_pkg::FRAC_W;
    localparam int GAIN_W   = rsb_pkg::GAIN_W;
    localparam int N        = 2;

    logic              r_valid [N];
    logic [N:0]        w_ld;

    logic              r_inside, n_inside;
    logic [PROD_W-1:0] r_prod, n_prod;
    rsb_pkg::t_rgba    r_pix;
    rsb_pkg::t_gain_beat r_beat, n_beat;

    logic [RQ_W-1:0]     w_rq_full;
    logic [FRAC_W:0]     w_rq, w_diff;
    logic [FRAC_W+2:0]   w_five;

    assign w_ld[N] = i_ready;
    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_ld
            assign w_ld[k] = !r_valid[k] || w_ld[k+1];
        end
    endgenerate
    assign o_ready = w_ld[0];

    // Inside test and ratio product
    assign n_inside = CMP_W'(i_root) < CMP_W'(i_cfg.radius_fixed);
    assign n_prod   = PROD_W'(i_root) * PROD_W'(i_cfg.inverse_radius);

    // Clamp ratio at one, then gain = 1 + 2.5 * (1 - ratio)
    assign w_rq_full = r_prod[PROD_W-1:RQ_SHIFT];
    assign w_rq      = (w_rq_full > RQ_W'(rsb_pkg::ONE_Q14)) ? rsb_pkg::ONE_Q14
                                                             : w_rq_full[FRAC_W:0];
    assign w_diff    = rsb_pkg::ONE_Q14 - w_rq;
    assign w_five    = {w_diff, 2'b00} + (FRAC_W + 3)'(w_diff);
    assign n_beat    = '{in_disc: r_inside,
                         gain:    GAIN_W'(rsb_pkg::ONE_Q14) + w_five[FRAC_W+2:1],
                         pix:     r_pix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
            r_valid[1] <= 1'b0;
        end else begin
            if (w_ld[0]) r_valid[0] <= i_valid;
            if (w_ld[1]) r_valid[1] <= r_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_inside <= n_inside;
            r_prod   <= n_prod;
            r_pix    <= i_pix;
        end
        if (w_ld[1]) begin
            r_beat   <= n_beat;
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

[rtl/core/rsb_scale.sv]
`default_nettype none

module rsb_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_light_enable,
    input  logic                i_valid,
    output logic                o_ready,
    input  rsb_pkg::t_gain_beat i_beat,
    output logic                o_valid,
    input  logic                i_ready,
    output rsb_pkg::t_out_beat  o_beat
);

    localparam int CHAN_W  = rsb_pkg::CHAN_W;
    localparam int CPROD_W = rsb_pkg::CPROD_W;
    localparam int FRAC_W  = rsb_pkg::FRAC_W;
    localparam int N       = 2;

    logic               r_valid [N];
    logic [N:0]         w_ld;

    logic [CPROD_W-1:0] r_pr, r_pg, r_pb;
    logic               r_pass;
    rsb_pkg::t_rgba     r_pix;
    rsb_pkg::t_out_beat r_out, n_out;

    // Drop the fraction and saturate at full scale
    function automatic logic [CHAN_W-1:0] f_sat(input logic [CPROD_W-1:0] p);
        logic [CPROD_W-FRAC_W-1:0] v;
        v = p[CPROD_W-1:FRAC_W];
        return (|v[CPROD_W-FRAC_W-1:CHAN_W]) ? {CHAN_W{1'b1}} : v[CHAN_W-1:0];
    endfunction

    assign w_ld[N] = i_ready;
    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_ld
            assign w_ld[k] = !r_valid[k] || w_ld[k+1];
        end
    endgenerate
    assign o_ready = w_ld[0];

    assign n_out.out_red   = r_pass ? r_pix.red   : f_sat(r_pr);
    assign n_out.out_green = r_pass ? r_pix.green : f_sat(r_pg);
    assign n_out.out_blue  = r_pass ? r_pix.blue  : f_sat(r_pb);
    assign n_out.out_alpha = r_pix.alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
            r_valid[1] <= 1'b0;
        end else begin
            if (w_ld[0]) r_valid[0] <= i_valid;
            if (w_ld[1]) r_valid[1] <= r_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_pr   <= CPROD_W'(i_beat.pix.red)   * CPROD_W'(i_beat.gain);
            r_pg   <= CPROD_W'(i_beat.pix.green) * CPROD_W'(i_beat.gain);
            r_pb   <= CPROD_W'(i_beat.pix.blue)  * CPROD_W'(i_beat.gain);
            r_pass <= !i_light_enable || !i_beat.in_disc;
            r_pix  <= i_beat.pix;
        end
        if (w_ld[1]) begin
            r_out  <= n_out;
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_beat  = r_out;

endmodule

`default_nettype wire

[bench/tb_radial_spotlight_brighten_top.sv]
`default_nettype none

module tb_radial_spotlight_brighten_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsb_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 10;
    // 28 stages with 12-bit coordinates
    localparam int PIPE_LATENCY     = 28;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int HOLD_BURST       = 60;
    localparam int PHASE_PIXELS     = 83;
    localparam int COORD_MAX        = (1 << COORD_BITS) - 1;
    localparam logic [31:0] INV_MAX = 32'd16777216;

    // Fixed-point layout of the brightening arithmetic
    localparam int          Q14_BITS    = 14;
    localparam int          RATIO_SHIFT = 18;
    localparam logic [63:0] UNITY_Q14   = 64'd16384;

    typedef enum {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} t_pressure;

    // Tracks the register file, predicts each output pixel and compares in order
    class spotlight_scoreboard;
        t_cfg        cfg;
        t_out_beat   due_pixels[$];
        int unsigned checked;
        int unsigned lit;
        int unsigned clipped;
        int unsigned errors;

        function new();
            cfg.light_enable   = 1'b0;
            cfg.frame_width    = RST_FRAME_WIDTH;
            cfg.frame_height   = RST_FRAME_HEIGHT;
            cfg.radius_fixed   = RST_RADIUS_FIXED;
            cfg.inverse_radius = RST_INVERSE_RADIUS;
            checked = 0;
            lit     = 0;
            clipped = 0;
            errors  = 0;
        endfunction

        // Keep only the register's own width of the written word
        function void track_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_LIGHT_ENABLE:   cfg.light_enable   = data[0];
                REG_FRAME_WIDTH:    cfg.frame_width    = data[DIM_W-1:0];
                REG_FRAME_HEIGHT:   cfg.frame_height   = data[DIM_W-1:0];
                REG_RADIUS_FIXED:   cfg.radius_fixed   = data[RAD_W-1:0];
                REG_INVERSE_RADIUS: cfg.inverse_radius = data[INV_W-1:0];
                default: ;
            endcase
        endfunction

        // Largest r with r*r <= v, built one bit at a time from the top
        function logic [63:0] floor_root(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int k = 31; k >= 0; k--) begin
                trial = root | (64'd1 << k);
                if (trial * trial <= v) root = trial;
            end
            return root;
        endfunction

        function logic [7:0] apply_gain(logic [7:0] c, logic [63:0] gain);
            logic [63:0] p;
            p = (64'(c) * gain) >> Q14_BITS;
            if (p > 64'd255) begin
                clipped++;
                return 8'd255;
            end
            return p[7:0];
        endfunction

        function t_out_beat brighten(t_in_beat px);
            logic [63:0] tx, ty, dx, dy, dq, rq, gain;
            t_out_beat   res;
            res.out_red   = px.in_red;
            res.out_green = px.in_green;
            res.out_blue  = px.in_blue;
            res.out_alpha = px.in_alpha;
            if (cfg.light_enable) begin
                // doubled offsets from the centre stay exact for odd sizes
                tx = 64'(px.pixel_x) << 1;
                ty = 64'(px.pixel_y) << 1;
                dx = (tx >= 64'(cfg.frame_width)) ? tx - 64'(cfg.frame_width)
                                                  : 64'(cfg.frame_width) - tx;
                dy = (ty >= 64'(cfg.frame_height)) ? ty - 64'(cfg.frame_height)
                                                   : 64'(cfg.frame_height) - ty;
                dq = floor_root((dx * dx + dy * dy) << Q14_BITS);
                if (dq < 64'(cfg.radius_fixed)) begin
                    lit++;
                    rq = (dq * 64'(cfg.inverse_radius)) >> RATIO_SHIFT;
                    if (rq > UNITY_Q14) rq = UNITY_Q14;
                    gain = UNITY_Q14 + ((64'd5 * (UNITY_Q14 - rq)) >> 1);
                    res.out_red   = apply_gain(px.in_red, gain);
                    res.out_green = apply_gain(px.in_green, gain);
                    res.out_blue  = apply_gain(px.in_blue, gain);
                end
            end
            return res;
        endfunction

        function void note_pixel(t_in_beat px);
            due_pixels.push_back(brighten(px));
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (due_pixels.size() == 0) begin
                errors++;
                $error("output beat %h arrived with no pixel outstanding", got);
                return;
            end
            want = due_pixels.pop_front();
            checked++;
            if (got.out_red !== want.out_red) begin
                errors++;
                $error("out_red: expected %0d, got %0d", want.out_red, got.out_red);
            end
            if (got.out_green !== want.out_green) begin
                errors++;
                $error("out_green: expected %0d, got %0d", want.out_green, got.out_green);
            end
            if (got.out_blue !== want.out_blue) begin
                errors++;
                $error("out_blue: expected %0d, got %0d", want.out_blue, got.out_blue);
            end
            if (got.out_alpha !== want.out_alpha) begin
                errors++;
                $error("out_alpha: expected %0d, got %0d", want.out_alpha, got.out_alpha);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_in_beat             i_beat;
    logic                 o_valid;
    logic                 i_stall;
    t_out_beat            o_beat;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    spotlight_scoreboard sb;
    bit                  long_hold = 1'b0;
    int unsigned         cycle_count;
    int unsigned         settings_count = 0;

    radial_spotlight_brighten_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_beat      (i_beat),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_beat      (o_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Check every output beat taken at an edge; values read here are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_beat);
    end

    // Receiver back-pressure: alternate free runs and stalls of random length.
    // A long hold-off is served here when the stimulus asks for one, so the
    // pipe fills behind the held output beat and the input stalls.
    initial begin : sink_stall
        bit          stalling;
        int unsigned run_left;
        stalling = 1'b0;
        run_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
                // next edge flips back to a free run
                stalling = 1'b1;
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    stalling = !stalling;
                    if (stalling)
                        run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                                : $urandom_range(8, 40);
                    else
                        run_left = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 8)
                                                                : $urandom_range(30, 120);
                end
                run_left--;
                i_stall <= stalling;
            end
        end
    end

    // Give up on a hung run
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Mostly back-to-back, often a short breath, now and then a long pause
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Lean towards black and full scale so saturation and zero both show up
    function automatic logic [7:0] random_channel();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Aim most pixels at the disc and its rim, the rest across the frame and
    // the full coordinate range
    function automatic t_in_beat random_pixel();
        int          cx, cy, rp, x, y;
        int unsigned r;
        t_in_beat    px;
        rp = int'(sb.cfg.radius_fixed >> 8);
        cx = int'(sb.cfg.frame_width) / 2;
        cy = int'(sb.cfg.frame_height) / 2;
        r  = $urandom_range(0, 99);
        if (r < 55) begin
            x = cx + int'($urandom_range(0, 2 * rp + 8)) - (rp + 4);
            y = cy + int'($urandom_range(0, 2 * rp + 8)) - (rp + 4);
        end else if (r < 80) begin
            x = int'($urandom_range(0, int'(sb.cfg.frame_width) - 1));
            y = int'($urandom_range(0, int'(sb.cfg.frame_height) - 1));
        end else begin
            x = int'($urandom_range(0, COORD_MAX));
            y = int'($urandom_range(0, COORD_MAX));
        end
        if (x < 0) x = 0;
        if (x > COORD_MAX) x = COORD_MAX;
        if (y < 0) y = 0;
        if (y > COORD_MAX) y = COORD_MAX;
        px.pixel_x  = COORD_BITS'(x);
        px.pixel_y  = COORD_BITS'(y);
        px.in_red   = random_channel();
        px.in_green = random_channel();
        px.in_blue  = random_channel();
        px.in_alpha = 8'($urandom_range(0, 255));
        return px;
    endfunction

    // Disc radius in Q13.8 at 0.45 of the frame height
    function automatic logic [31:0] radius_for(int unsigned h);
        return 32'((h * 256 * 45) / 100);
    endfunction

    // Reciprocal of the radius in pixels, Q1.24, capped at one (INV_MAX)
    function automatic logic [31:0] inverse_for(logic [31:0] rad);
        logic [63:0] q;
        if (rad == 0) return 32'd0;
        q = 64'h1_0000_0000 / 64'(rad);
        if (q > 64'(INV_MAX)) q = 64'(INV_MAX);
        return q[31:0];
    endfunction

    // Offer one beat and hold it until taken; valid is left high for the caller
    task automatic send_pixel(t_in_beat px);
        i_valid <= 1'b1;
        i_beat  <= px;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(px);
    endtask

    task automatic rest_sender(int unsigned n);
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every predicted pixel has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.due_pixels.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write one register; with junk set, fill the bits above its width with noise
    task automatic put_reg(t_reg_idx idx, int unsigned bits, logic [31:0] value, bit junk);
        logic [CFG_W-1:0] data;
        data = CFG_W'(value);
        if (junk)
            data = data | (CFG_W'($urandom) & ~((CFG_W'(1) << bits) - CFG_W'(1)));
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.track_reg(idx, data);
    endtask

    // Only called with the pipe empty
    task automatic load_setting(bit en, int unsigned w, int unsigned h,
                                logic [31:0] rad, logic [31:0] inv, bit junk);
        put_reg(REG_LIGHT_ENABLE,   1,     32'(en), junk);
        put_reg(REG_FRAME_WIDTH,    DIM_W, w,       junk);
        put_reg(REG_FRAME_HEIGHT,   DIM_W, h,       junk);
        put_reg(REG_RADIUS_FIXED,   RAD_W, rad,     junk);
        put_reg(REG_INVERSE_RADIUS, INV_W, inv,     junk);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic drive_pixel(int x, int y, int r, int g, int b, int a);
        t_in_beat px;
        px.pixel_x  = COORD_BITS'(x);
        px.pixel_y  = COORD_BITS'(y);
        px.in_red   = 8'(r);
        px.in_green = 8'(g);
        px.in_blue  = 8'(b);
        px.in_alpha = 8'(a);
        send_pixel(px);
        rest_sender(pick_gap());
    endtask

    // One stretch of random pixels under the current registers.
    // PRESS_HOLD asks the receiver for its long hold-off and keeps offering
    // back-to-back; PRESS_PAUSE stops halfway until the pipe is empty.
    task automatic run_phase(int unsigned n, t_pressure press, bit steady);
        int unsigned no_gap_left;
        no_gap_left = 0;
        for (int unsigned i = 0; i < n; i++) begin
            send_pixel(random_pixel());
            if (press == PRESS_HOLD && i == n / 4) begin
                long_hold   = 1'b1;
                no_gap_left = HOLD_BURST;
            end
            if (press == PRESS_PAUSE && i == n / 2)
                drain_results();
            else if (steady)
                ;
            else if (no_gap_left != 0)
                no_gap_left--;
            else
                rest_sender(pick_gap());
        end
        drain_results();
    endtask

    initial begin : stimulus
        int unsigned w, h;
        logic [31:0] rad;

        sb = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_beat      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_LIGHT_ENABLE;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Light off after reset: everything passes untouched
        drive_pixel(320, 240, 255, 255, 255, 255);
        drive_pixel(COORD_MAX, COORD_MAX, 200, 17, 90, 3);
        drain_results();

        // Reset geometry with the light on
        load_setting(1'b1, 640, 480, 55296, 77672, 1'b0);
        drive_pixel(320, 240, 255, 255, 255, 0);     // centre, full gain, all clip
        drive_pixel(320, 240, 0, 0, 0, 255);         // black stays black
        drive_pixel(320, 240, 73, 1, 128, 170);      // just under full scale
        drive_pixel(535, 240, 100, 100, 100, 1);     // last column inside the disc
        drive_pixel(536, 240, 100, 100, 100, 2);     // on the rim counts as outside
        drive_pixel(320, 25, 90, 90, 90, 3);         // top edge, inside
        drive_pixel(320, 24, 90, 90, 90, 4);         // top rim, outside
        drive_pixel(400, 300, 150, 60, 30, 5);
        drive_pixel(0, 0, 255, 255, 255, 6);
        drive_pixel(COORD_MAX, 0, 1, 2, 3, 7);
        drive_pixel(0, COORD_MAX, 4, 5, 6, 8);
        drive_pixel(COORD_MAX, COORD_MAX, 7, 8, 9, 9);
        drain_results();

        // Zero radius: nothing is inside
        load_setting(1'b1, 640, 480, 0, 77672, 1'b0);
        drive_pixel(320, 240, 120, 120, 120, 10);
        drive_pixel(321, 240, 120, 120, 120, 11);
        drain_results();

        // Oversized reciprocal: off centre the ratio clamps at one and gain falls to unity; the centre keeps full gain
        load_setting(1'b1, 640, 480, 55296, INV_MAX, 1'b0);
        drive_pixel(400, 240, 60, 60, 60, 12);
        drive_pixel(320, 240, 60, 60, 60, 13);
        drain_results();

        // Zero reciprocal: full gain anywhere inside the disc
        load_setting(1'b1, 640, 480, 55296, 0, 1'b0);
        drive_pixel(500, 240, 40, 40, 40, 14);
        drain_results();

        // Random stretches, one register setting each
        load_setting(1'b1, 640, 480, 55296, 77672, 1'b0);
        run_phase(PHASE_PIXELS, PRESS_HOLD, 1'b0);

        // Largest frame, disc reaches past every corner
        load_setting(1'b1, 4096, 4096, 1048576, inverse_for(1048576), 1'b0);
        run_phase(PHASE_PIXELS, PRESS_PAUSE, 1'b0);

        // Smallest frame
        load_setting(1'b1, 1, 1, 256, inverse_for(256), 1'b0);
        run_phase(PHASE_PIXELS, PRESS_NONE, 1'b0);

        w = $urandom_range(1, 4096);
        h = $urandom_range(1, 4096);
        load_setting(1'b0, w, h, radius_for(h), inverse_for(radius_for(h)), 1'b0);
        run_phase(PHASE_PIXELS, PRESS_NONE, 1'b0);

        w = $urandom_range(1, 4096);
        h = $urandom_range(1, 4096);
        load_setting(1'b1, w, h, 0, inverse_for(radius_for(h)), 1'b0);
        run_phase(PHASE_PIXELS, PRESS_NONE, 1'b0);

        w = $urandom_range(1, 4096);
        h = $urandom_range(1, 4096);
        load_setting(1'b1, w, h, radius_for(h), INV_MAX, 1'b0);
        run_phase(PHASE_PIXELS, PRESS_NONE, 1'b0);

        w = $urandom_range(1, 4096);
        h = $urandom_range(1, 4096);
        load_setting(1'b1, w, h, radius_for(h), 0, 1'b0);
        run_phase(PHASE_PIXELS, PRESS_NONE, 1'b0);

        // Noise above each register's width must be dropped; stream without gaps
        w   = $urandom_range(1, 4096);
        h   = $urandom_range(1, 4096);
        rad = radius_for(h);
        load_setting(1'b1, w, h, rad, inverse_for(rad), 1'b1);
        run_phase(PHASE_PIXELS, PRESS_NONE, 1'b1);

        for (int k = 0; k < 2; k++) begin
            w   = $urandom_range(1, 4096);
            h   = $urandom_range(1, 4096);
            rad = 32'($urandom_range(0, 1048576));
            load_setting(1'b1, w, h, rad, inverse_for(rad), 1'b0);
            run_phase(PHASE_PIXELS, PRESS_NONE, 1'b0);
        end

        // Let any stray beat surface before judging
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);

        $display("Checked %0d pixels over %0d register settings in %0d cycles.",
                 sb.checked, settings_count, cycle_count);
        $display("%0d pixels fell inside the lit disc; %0d colour channels clipped at 255.",
                 sb.lit, sb.clipped);
        if (sb.errors == 0 && sb.due_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

[radial_spotlight_brighten_top.f]
+incdir+rtl/core
rtl/core/rsb_pkg.sv
rtl/core/rsb_offset_sq.sv
rtl/core/rsb_isqrt.sv
rtl/core/rsb_gain.sv
rtl/core/rsb_scale.sv
rtl/core/radial_spotlight_brighten_top.sv
bench/tb_radial_spotlight_brighten_top.sv
